// File: hw/rtl/api_frame_receive_parser_unit_assert.svh
// Assertion macros used by the frame parser core (afrp_core).
`ifndef API_FRAME_RECEIVE_PARSER_UNIT_ASSERT_SVH
`define API_FRAME_RECEIVE_PARSER_UNIT_ASSERT_SVH

// Check a property while out of reset.
`define AFRP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("frame parser assertion failed");

// Check a property at every edge, reset included.
`define AFRP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("frame parser assertion failed");

`endif

// File: hw/rtl/afrp_pkg.sv
// Types and constants of the API frame receive parser.
`default_nettype none
package afrp_pkg;

    // Result kinds
    localparam logic [2:0] K_PAYLOAD = 3'd0;
    localparam logic [2:0] K_ACCEPT  = 3'd1;
    localparam logic [2:0] K_BADSUM  = 3'd2;
    localparam logic [2:0] K_ZEROLEN = 3'd3;
    localparam logic [2:0] K_BADID   = 3'd4;
    localparam logic [2:0] K_SHORT   = 3'd5;
    localparam logic [2:0] K_LONG    = 3'd6;

    // Frame constants
    localparam logic [7:0] START_BYTE    = 8'h7E;
    localparam logic [3:0] HEADER_BYTES  = 4'd11;
    localparam logic [7:0] CHECK_BASE    = 8'hFF;
    localparam logic [7:0] FRAME_ID_INIT = 8'd128;
    localparam int         PAYLOAD_LIMIT = 128;

    // One item held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_item;

    // One result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [6:0]  payload_index;
        logic [63:0] src_address;
        logic [15:0] src_short;
        logic [7:0]  options;
        logic [7:0]  payload_length;
    } t_result;

endpackage
`default_nettype wire

// File: hw/rtl/api_frame_receive_parser_unit.sv
// Top level of the API frame receive parser.
//
// Input channel: one received serial byte per item on i_rx_byte, handshaked
// by i_in_valid / o_in_ready. Output channel: one result item per payload
// byte (kind 0 with data and index) and one end item per frame giving the
// outcome and the header fields, handshaked by o_out_valid / i_out_ready.
// The receive identifier is written through i_cfg_wr_en / i_cfg_wr_data.
// Throughput is one item per cycle while results are taken: the whole frame
// step is a single pass of logic between the input register and the result register.
// A result item is built by the frame logic from the item in the input
// register and loads into the result register when the core takes that
// item, which waits while the result register is blocked.
// Reset (synchronous, active low) empties both registers, sets the parser
// to hunt for the start byte and restores the identifier to 128.
// When the receiver stalls, the result register holds, the input register
// keeps one more item, and o_in_ready drops until the result is taken.
// Consumers discard payload bytes unless the end item reports accepted.
`default_nettype none
module api_frame_receive_parser_unit
    import afrp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_data,
    output logic [6:0]       o_payload_index,
    output logic [63:0]      o_src_address,
    output logic [15:0]      o_src_short,
    output logic [7:0]       o_options,
    output logic [7:0]       o_payload_length
);

    t_item   w_item;
    t_result w_result;
    logic    w_free;

    // Input register
    afrp_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .i_free     (w_free),
        .o_item     (w_item)
    );

    // Frame logic and result register
    afrp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (w_item),
        .o_free        (w_free),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result      (w_result)
    );

    // Break the result out onto its ports
    assign o_kind           = w_result.kind;
    assign o_data           = w_result.data;
    assign o_payload_index  = w_result.payload_index;
    assign o_src_address    = w_result.src_address;
    assign o_src_short      = w_result.src_short;
    assign o_options        = w_result.options;
    assign o_payload_length = w_result.payload_length;

endmodule
`default_nettype wire

// File: hw/rtl/afrp_in_stage.sv
// Input register of the frame parser.
`default_nettype none
module afrp_in_stage
    import afrp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_free,
    output t_item           o_item
);

    t_item r_item;
    logic  w_take;

    // Hand the held item on when the core can take it
    assign w_take     = r_item.valid && i_free;
    assign o_in_ready = !r_item.valid || i_free;
    assign o_item     = r_item;

    // Load a new item or drop the consumed one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_item.valid   <= 1'b1;
            r_item.rx_byte <= i_rx_byte;
        end else if (w_take) begin
            r_item.valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/afrp_core.sv
// Frame state machine, checksum and result register of the frame parser.
`default_nettype none
`include "api_frame_receive_parser_unit_assert.svh"
module afrp_core
    import afrp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    input  wire t_item      i_item,
    output logic            o_free,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_result         o_result
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_IDENT   = 3'd3,
        PH_HEADER  = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CHECK   = 3'd6
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_sum, n_sum;
    logic [3:0]  r_hcount, n_hcount;
    logic [63:0] r_src_long, n_src_long;
    logic [15:0] r_src_short, n_src_short;
    logic [7:0]  r_options, n_options;
    logic [7:0]  r_pcount, n_pcount;
    logic [7:0]  r_frame_id;
    logic        r_out_valid;
    t_result     r_out, n_out;

    logic        w_take;
    logic        w_end;
    logic        w_payload;
    logic [2:0]  w_kind;
    logic [7:0]  b;

    assign b           = i_item.rx_byte;
    assign o_free      = !r_out_valid || i_out_ready;
    assign w_take      = i_item.valid && o_free;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // Advance the frame state by one received byte
    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_sum       = r_sum;
        n_hcount    = r_hcount;
        n_src_long  = r_src_long;
        n_src_short = r_src_short;
        n_options   = r_options;
        n_pcount    = r_pcount;
        w_end       = 1'b0;
        w_payload   = 1'b0;
        w_kind      = K_PAYLOAD;
        case (r_phase)
            PH_LEN_HI: begin
                n_len   = {b, 8'h00};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len = {r_len[15:8], b};
                if (n_len == 16'd0) begin
                    w_end  = 1'b1;
                    w_kind = K_ZEROLEN;
                end else begin
                    n_phase = PH_IDENT;
                end
            end
            PH_IDENT: begin
                n_sum = r_sum + b;
                n_len = r_len - 16'd1;
                if (b != r_frame_id) begin
                    w_end  = 1'b1;
                    w_kind = K_BADID;
                end else if (n_len < {12'd0, HEADER_BYTES}) begin
                    w_end  = 1'b1;
                    w_kind = K_SHORT;
                end else begin
                    n_hcount = 4'd0;
                    n_phase  = PH_HEADER;
                end
            end
            PH_HEADER: begin
                n_sum = r_sum + b;
                // Long address, then short address, then options, MSB first
                if (r_hcount < 4'd8) begin
                    n_src_long = {r_src_long[55:0], b};
                end else if (r_hcount < 4'd10) begin
                    n_src_short = {r_src_short[7:0], b};
                end else begin
                    n_options = b;
                end
                n_hcount = r_hcount + 4'd1;
                if (n_hcount == HEADER_BYTES) begin
                    n_len = r_len - {12'd0, HEADER_BYTES};
                    if (n_len > 16'(PAYLOAD_LIMIT)) begin
                        w_end  = 1'b1;
                        w_kind = K_LONG;
                    end else begin
                        n_pcount = 8'd0;
                        n_phase  = (n_len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_sum     = r_sum + b;
                w_payload = 1'b1;
                n_pcount  = r_pcount + 8'd1;
                n_len     = r_len - 16'd1;
                if (n_len == 16'd0) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                w_end  = 1'b1;
                w_kind = (b == (CHECK_BASE - r_sum)) ? K_ACCEPT : K_BADSUM;
            end
            default: begin
                // Hunt for the start byte; clear the frame on a match
                if (b == START_BYTE) begin
                    n_sum       = 8'd0;
                    n_hcount    = 4'd0;
                    n_src_long  = 64'd0;
                    n_src_short = 16'd0;
                    n_options   = 8'd0;
                    n_pcount    = 8'd0;
                    n_len       = 16'd0;
                    n_phase     = PH_LEN_HI;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
        if (w_end) begin
            n_phase = PH_HUNT;
        end
    end

    // Build the result item
    always_comb begin
        n_out = '0;
        if (w_end) begin
            n_out.kind           = w_kind;
            n_out.src_address    = n_src_long;
            n_out.src_short      = n_src_short;
            n_out.options        = n_options;
            n_out.payload_length = n_pcount;
        end else begin
            n_out.kind          = K_PAYLOAD;
            n_out.data          = b;
            n_out.payload_index = r_pcount[6:0];
        end
    end

    // Hold frame state, the receive identifier and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_len       <= 16'd0;
            r_sum       <= 8'd0;
            r_hcount    <= 4'd0;
            r_src_long  <= 64'd0;
            r_src_short <= 16'd0;
            r_options   <= 8'd0;
            r_pcount    <= 8'd0;
            r_frame_id  <= FRAME_ID_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_frame_id <= i_cfg_wr_data;
            end
            if (w_take) begin
                r_phase     <= n_phase;
                r_len       <= n_len;
                r_sum       <= n_sum;
                r_hcount    <= n_hcount;
                r_src_long  <= n_src_long;
                r_src_short <= n_src_short;
                r_options   <= n_options;
                r_pcount    <= n_pcount;
            end
            if (w_take && (w_end || w_payload)) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The header counter stays inside the header while reading it
    `AFRP_ASSERT(a_hcount_bound, i_clk, i_rst_n,
        (r_phase == PH_HEADER) |-> (r_hcount < HEADER_BYTES))
    // A payload phase always has bytes left, within the limit
    `AFRP_ASSERT(a_payload_left, i_clk, i_rst_n,
        (r_phase == PH_PAYLOAD) |-> ((r_len != 16'd0) && (r_len <= 16'(PAYLOAD_LIMIT))))
    // A blocked result register freezes the frame state
    `AFRP_ASSERT(a_stall_holds, i_clk, i_rst_n,
        (i_item.valid && !o_free) |=> $stable(r_phase))
    // No result is shown right after reset
    `AFRP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !r_out_valid)

endmodule
`default_nettype wire
